// ===== src/shc_pkg.sv =====
// ----------------------------------------------------------------------------
// Signature hit counter package
// Beat types, register indexes and default sizes shared by the block.
// ----------------------------------------------------------------------------
package shc_pkg;

  localparam int unsigned MAX_SIG_LEN_DFLT   = 5;
  localparam int unsigned HIT_COUNT_MAX_DFLT = 15;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 40;
  localparam int unsigned SIG_LEN_W  = 3;
  localparam int unsigned MIN_HITS_W = 4;
  localparam int unsigned HIT_TOT_W  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SIGNATURE_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNATURE_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HITS         = 2'd2;

  localparam logic [SIG_LEN_W-1:0]  SIG_LEN_RESET  = 3'd3;
  localparam logic [MIN_HITS_W-1:0] MIN_HITS_RESET = 4'd1;

  typedef struct packed {
    logic [7:0] rom_byte;
    logic       last_byte;
  } byte_beat_t;

  typedef struct packed {
    logic                 found;
    logic [HIT_TOT_W-1:0] hit_total;
  } result_beat_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_beat_t;

endpackage

// ===== src/shc_stream_if.sv =====
// ----------------------------------------------------------------------------
// Signature hit counter stream interface
// Valid/ready channel with a typed payload; a beat moves when both are high.
// ----------------------------------------------------------------------------
interface shc_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (
    output valid,
    output payload,
    input  ready
  );

  modport sink (
    input  valid,
    input  payload,
    output ready
  );

endinterface

// ===== src/signature_hit_counter_core.sv =====
// ----------------------------------------------------------------------------
// Signature hit counter core
// Counts leftmost, non-overlapping matches of a configured byte signature in
// a stream of image bytes and reports the total on the final byte.
// ----------------------------------------------------------------------------
// The block takes one image byte per cycle unless stalled: the window shift,
// the signature compare and the counter update all complete in the cycle the
// beat is accepted, and the result for the final byte appears in the output
// register on the next cycle. A new byte is taken while a result waits, as
// long as the output register is free or being emptied in the same cycle.
// Configuration is written through its own channel, which is always ready.
module signature_hit_counter_core #(
  parameter int unsigned MAX_SIG_LEN   = shc_pkg::MAX_SIG_LEN_DFLT,
  parameter int unsigned HIT_COUNT_MAX = shc_pkg::HIT_COUNT_MAX_DFLT
) (
  input logic         clk_i,
  input logic         rst_ni,
  shc_stream_if.sink   cfg_chan_i,
  shc_stream_if.sink   byte_chan_i,
  shc_stream_if.source result_chan_o
);

  import shc_pkg::*;

  localparam int unsigned SIG_W  = 8 * MAX_SIG_LEN;
  localparam int unsigned LEN_W  = $clog2(MAX_SIG_LEN + 1);
  localparam int unsigned HCNT_W = $clog2(HIT_COUNT_MAX + 1);
  localparam int unsigned CMP_W  = (HCNT_W > MIN_HITS_W) ? HCNT_W : MIN_HITS_W;

  logic [SIG_W-1:0]      sig_q;
  logic [SIG_LEN_W-1:0]  sig_len_q;
  logic [MIN_HITS_W-1:0] min_hits_q;

  logic [SIG_W-1:0]  win_q, win_d;
  logic [LEN_W-1:0]  fill_q, fill_d;
  logic [LEN_W-1:0]  skip_q, skip_d;
  logic [HCNT_W-1:0] hits_q, hits_d;

  logic               res_valid_q;
  result_beat_t       res_q;
  result_beat_t       res_d;

  logic [LEN_W-1:0]     eff_len;
  logic [MAX_SIG_LEN:0] match_len;
  logic                 hit;
  logic                 cfg_fire;
  logic                 in_fire;
  logic                 out_fire;
  logic [CMP_W-1:0]     hits_ext;
  logic [CMP_W-1:0]     min_ext;

  assign cfg_chan_i.ready = 1'b1;
  assign cfg_fire         = cfg_chan_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_q      <= '0;
      sig_len_q  <= SIG_LEN_RESET;
      min_hits_q <= MIN_HITS_RESET;
    end else if (cfg_fire) begin
      case (cfg_chan_i.payload.reg_index)
        REG_SIGNATURE_BYTES:  sig_q      <= SIG_W'(cfg_chan_i.payload.wdata);
        REG_SIGNATURE_LENGTH: sig_len_q  <= cfg_chan_i.payload.wdata[SIG_LEN_W-1:0];
        REG_MIN_HITS:         min_hits_q <= cfg_chan_i.payload.wdata[MIN_HITS_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_fire          = res_valid_q && result_chan_o.ready;
  assign byte_chan_i.ready = !res_valid_q || result_chan_o.ready;
  assign in_fire           = byte_chan_i.valid && byte_chan_i.ready;

  always_comb begin
    if (sig_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(sig_len_q) > MAX_SIG_LEN) begin
      eff_len = LEN_W'(MAX_SIG_LEN);
    end else begin
      eff_len = LEN_W'(sig_len_q);
    end
  end

  assign win_d  = SIG_W'({win_q, byte_chan_i.payload.rom_byte});
  assign fill_d = (32'(fill_q) < MAX_SIG_LEN) ? fill_q + LEN_W'(1) : fill_q;

  // The newest byte sits in the low lane and lines up with the last
  // signature byte in use.
  always_comb begin
    match_len[0] = 1'b0;
    for (int l = 1; l <= MAX_SIG_LEN; l++) begin
      match_len[l] = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (win_d[8*(l-1-k) +: 8] != sig_q[8*k +: 8]) begin
          match_len[l] = 1'b0;
        end
      end
    end
  end

  assign hit = (fill_d >= eff_len) && match_len[eff_len];

  always_comb begin
    skip_d = skip_q;
    hits_d = hits_q;
    if (skip_q != '0) begin
      skip_d = skip_q - LEN_W'(1);
    end else if (hit) begin
      skip_d = eff_len;
      if (32'(hits_q) < HIT_COUNT_MAX) begin
        hits_d = hits_q + HCNT_W'(1);
      end
    end
  end

  assign hits_ext        = CMP_W'(hits_q);
  assign min_ext         = CMP_W'(min_hits_q);
  assign res_d.found     = hits_ext >= min_ext;
  assign res_d.hit_total = hits_ext[HIT_TOT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= '0;
      skip_q <= '0;
      hits_q <= '0;
    end else if (in_fire) begin
      if (byte_chan_i.payload.last_byte) begin
        win_q  <= '0;
        fill_q <= '0;
        skip_q <= '0;
        hits_q <= '0;
      end else begin
        win_q  <= win_d;
        fill_q <= fill_d;
        skip_q <= skip_d;
        hits_q <= hits_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (in_fire && byte_chan_i.payload.last_byte) begin
      res_valid_q <= 1'b1;
    end else if (out_fire) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && byte_chan_i.payload.last_byte) begin
      res_q <= res_d;
    end
  end

  assign result_chan_o.valid   = res_valid_q;
  assign result_chan_o.payload = res_q;

endmodule

// ===== dv/signature_hit_counter_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Signature hit counter core testbench
// Streams images of random and signature-rich bytes through the block under
// shifting register settings and random byte and result stalls, predicts the
// found flag and hit total of each image, and checks every result beat.
// ----------------------------------------------------------------------------
module signature_hit_counter_core_tb;
  import shc_pkg::*;

  localparam int unsigned CLK_HALF     = 4;
  localparam int unsigned ITEM_TARGET  = 550;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned SIG_LEN_MAX  = MAX_SIG_LEN_DFLT;
  localparam int unsigned HIT_MAX      = HIT_COUNT_MAX_DFLT;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int unsigned {
    IMG_NOISE,
    IMG_SPRINKLED,
    IMG_DENSE
  } image_style_e;

  class hit_scoreboard;
    logic [CFG_DATA_W-1:0]    sig_bytes;
    logic [SIG_LEN_W-1:0]     sig_len;
    logic [MIN_HITS_W-1:0]    min_hits;
    logic [8*SIG_LEN_MAX-1:0] window;
    int unsigned              fill;
    int unsigned              skip_left;
    int unsigned              hits;
    result_beat_t             totals_due[$];
    int unsigned              errors;

    function new();
      sig_bytes = '0;
      sig_len   = SIG_LEN_RESET;
      min_hits  = MIN_HITS_RESET;
      errors    = 0;
      clear_image();
    endfunction

    function void clear_image();
      window    = '0;
      fill      = 0;
      skip_left = 0;
      hits      = 0;
    endfunction

    function void write_register(cfg_beat_t beat);
      case (beat.reg_index)
        REG_SIGNATURE_BYTES:  sig_bytes = beat.wdata;
        REG_SIGNATURE_LENGTH: sig_len   = beat.wdata[SIG_LEN_W-1:0];
        REG_MIN_HITS:         min_hits  = beat.wdata[MIN_HITS_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned active_len();
      int unsigned l;
      l = sig_len;
      if (l == 0) l = 1;
      if (l > SIG_LEN_MAX) l = SIG_LEN_MAX;
      return l;
    endfunction

    // The oldest byte of the window lines up with the first signature byte.
    function bit window_hit(int unsigned len);
      for (int unsigned k = 0; k < len; k++) begin
        if (window[(len-1-k)*8 +: 8] !== sig_bytes[k*8 +: 8]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_byte(byte_beat_t beat);
      int unsigned  len;
      result_beat_t due;
      len    = active_len();
      window = {window[8*SIG_LEN_MAX-9:0], beat.rom_byte};
      if (fill < SIG_LEN_MAX) fill++;
      if (beat.last_byte) begin
        due.found     = (hits >= min_hits);
        due.hit_total = HIT_TOT_W'(hits);
        totals_due.push_back(due);
        clear_image();
      end else if (skip_left > 0) begin
        skip_left--;
      end else if (fill >= len && window_hit(len)) begin
        if (hits < HIT_MAX) hits++;
        skip_left = len;
      end
    endfunction

    function int unsigned pending();
      return totals_due.size();
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(result_beat_t got);
      result_beat_t due;
      if (totals_due.size() == 0) begin
        report($sformatf("result beat with no image pending (found %b total %0d)",
                         got.found, got.hit_total));
      end else begin
        due = totals_due.pop_front();
        if (got.found !== due.found)
          report($sformatf("found is %b, predicted %b", got.found, due.found));
        if (got.hit_total !== due.hit_total)
          report($sformatf("hit_total is %0d, predicted %0d", got.hit_total,
                           due.hit_total));
      end
    endtask

    task close();
      if (totals_due.size() != 0)
        report($sformatf("%0d result beats never arrived", totals_due.size()));
    endtask
  endclass

  logic          clk;
  logic          rst_n;
  int unsigned   cycle_count = 0;
  int unsigned   items_sent;
  bit            quiet_phase;
  hit_scoreboard sb = new();

  shc_stream_if #(.payload_t(cfg_beat_t))    cfg_if ();
  shc_stream_if #(.payload_t(byte_beat_t))   byte_if ();
  shc_stream_if #(.payload_t(result_beat_t)) res_if ();

  signature_hit_counter_core DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_chan_i    (cfg_if),
    .byte_chan_i   (byte_if),
    .result_chan_o (res_if)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1) sb.write_register(cfg_if.payload);
    if (byte_if.valid === 1'b1 && byte_if.ready === 1'b1) sb.note_byte(byte_if.payload);
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1) sb.check_result(res_if.payload);
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_word();
    return CFG_DATA_W'({$urandom(), $urandom()});
  endfunction

  initial begin
    int unsigned n;
    res_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      n = idle_len();
      if (n > 0) begin
        @(negedge clk);
        res_if.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk);
      res_if.ready <= 1'b1;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_beat_t beat;
    beat.reg_index = idx;
    beat.wdata     = data;
    @(negedge clk);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= beat;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_byte(byte_beat_t beat);
    int unsigned gap;
    gap = idle_len();
    repeat (gap) begin
      @(negedge clk);
      byte_if.valid <= 1'b0;
    end
    @(negedge clk);
    byte_if.valid   <= 1'b1;
    byte_if.payload <= beat;
    do @(posedge clk); while (byte_if.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic send_bytes(logic [7:0] img[$]);
    byte_beat_t beat;
    foreach (img[k]) begin
      beat.rom_byte  = img[k];
      beat.last_byte = (k == img.size() - 1);
      send_byte(beat);
    end
    @(negedge clk);
    byte_if.valid <= 1'b0;
  endtask

  task automatic run_image(int unsigned n, image_style_e style);
    logic [7:0]  img[$];
    int unsigned len;
    int unsigned r;
    len = sb.active_len();
    while (img.size() < n) begin
      r = $urandom_range(0, 9);
      if (style == IMG_NOISE) begin
        img.push_back(8'($urandom()));
      end else if (style == IMG_DENSE || r < 3) begin
        for (int unsigned k = 0; k < len; k++) img.push_back(sb.sig_bytes[k*8 +: 8]);
        if (style == IMG_DENSE && r < 2)
          img.push_back(sb.sig_bytes[$urandom_range(0, len - 1)*8 +: 8]);
      end else if (r < 6) begin
        img.push_back(sb.sig_bytes[$urandom_range(0, len - 1)*8 +: 8]);
      end else begin
        img.push_back(8'($urandom()));
      end
    end
    while (img.size() > n) void'(img.pop_back());
    send_bytes(img);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_config();
    logic [CFG_DATA_W-1:0] sig;
    logic [CFG_DATA_W-1:0] fill_word;
    logic [7:0]            b;
    logic [SIG_LEN_W-1:0]  len;
    logic [MIN_HITS_W-1:0] hits_needed;
    int unsigned           r;
    case ($urandom_range(0, 3))
      0: sig = rand_word();
      1: begin
        b   = 8'($urandom());
        sig = {5{b}};
      end
      2: for (int k = 0; k < CFG_DATA_W / 8; k++)
        sig[k*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: for (int k = 0; k < CFG_DATA_W / 8; k++)
        sig[k*8 +: 8] = 8'h41 + 8'($urandom_range(0, 1));
    endcase
    len = SIG_LEN_W'($urandom_range(0, 7));
    r   = $urandom_range(0, 5);
    hits_needed = (r == 0) ? '0 : (r == 1) ? '1 : MIN_HITS_W'($urandom_range(1, 4));
    write_cfg(REG_SIGNATURE_BYTES, sig);
    fill_word = rand_word();
    write_cfg(REG_SIGNATURE_LENGTH, {fill_word[CFG_DATA_W-1:SIG_LEN_W], len});
    fill_word = rand_word();
    write_cfg(REG_MIN_HITS, {fill_word[CFG_DATA_W-1:MIN_HITS_W], hits_needed});
    if ($urandom_range(0, 3) == 0) write_cfg(REG_UNUSED, rand_word());
  endtask

  initial begin
    logic [7:0]  img[$];
    int unsigned r;
    rst_n           = 1'b0;
    items_sent      = 0;
    quiet_phase     = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.payload  = '0;
    byte_if.valid   = 1'b0;
    byte_if.payload = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    img = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_bytes(img);
    img = '{8'h00, 8'h00};
    send_bytes(img);
    drain();
    write_cfg(REG_UNUSED, '1);
    write_cfg(REG_SIGNATURE_BYTES, 40'h00_00_00_00_FF);
    write_cfg(REG_SIGNATURE_LENGTH, {{(CFG_DATA_W-SIG_LEN_W){1'b1}}, 3'd0});
    write_cfg(REG_MIN_HITS, '0);
    img = '{8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h80, 8'h7F, 8'hFF};
    send_bytes(img);
    img = '{8'hFF};
    send_bytes(img);
    drain();
    write_cfg(REG_SIGNATURE_BYTES, 40'h05_04_03_02_01);
    write_cfg(REG_SIGNATURE_LENGTH, '1);
    write_cfg(REG_MIN_HITS, '1);
    img = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'hAA, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
    send_bytes(img);

    while (items_sent < ITEM_TARGET) begin
      drain();
      quiet_phase = ($urandom_range(0, 3) == 0);
      random_config();
      repeat ($urandom_range(3, 6)) begin
        r = $urandom_range(0, 9);
        if (r < 2) run_image($urandom_range(1, 6), IMG_NOISE);
        else if (r < 8) run_image($urandom_range(1, 16), IMG_SPRINKLED);
        else run_image($urandom_range(20, 40), IMG_DENSE);
      end
    end

    drain();
    sb.close();
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/shc_pkg.sv
src/shc_stream_if.sv
src/signature_hit_counter_core.sv
dv/signature_hit_counter_core_tb.sv
